// File: src/fpc_pkg.sv
package fpc_pkg;

    // fixed-point format of every stored value
    localparam int FRAC_BITS  = 16;
    localparam int NUM_PLANES = 6;
    localparam int PLANE_WORDS = NUM_PLANES * 4;
    // dividend of the normalize divider: 32-bit magnitude shifted up by FRAC_BITS
    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int ROOT_STEPS = 32;

    typedef enum logic [1:0] {
        FN_LOAD_COL  = 2'd0,
        FN_LOAD_AXIS = 2'd1,
        FN_SPHERE    = 2'd2,
        FN_BOX       = 2'd3
    } t_func;

    // x,y,z,w of a column, an axis or a plane (nx,ny,nz,d)
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_vec4;

    typedef t_vec4 [3:0]            t_clip;
    typedef t_vec4 [NUM_PLANES-1:0] t_planes;

    // per-cycle command to the plane lanes
    typedef struct packed {
        logic       go;
        logic [1:0] vec;
        logic [1:0] k;
    } t_lane_ctl;

    // right, left, bottom, top, far, near: row 3 plus or minus this row
    localparam logic [1:0] OTHER_ROW [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       ADD_ROW   [NUM_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    function automatic logic signed [31:0] row_of(input t_vec4 v, input logic [1:0] r);
        logic signed [31:0] res;
        case (r)
            2'd0:    res = v.x;
            2'd1:    res = v.y;
            2'd2:    res = v.z;
            default: res = v.w;
        endcase
        return res;
    endfunction

    // a +/- b saturated to 32 bits
    function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic add);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = add ? (33'(a) + 33'(b)) : (33'(a) - 33'(b));
        if (s[32] != s[31]) begin
            res = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

endpackage

// File: src/fpc_lane.sv
module fpc_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpc_pkg::t_vec4        i_plane,
    input  fpc_pkg::t_lane_ctl    i_ctl,
    input  logic signed [31:0]    i_opnd,
    output logic signed [63:0]    o_dist,
    output logic signed [63:0]    o_rad
);
    import fpc_pkg::*;

    logic signed [31:0] coef;
    logic signed [63:0] term;
    logic signed [63:0] acc_sum;
    logic signed [63:0] acc_abs;
    t_lane_ctl          r_ctl;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_dist;
    logic signed [63:0] r_rad;

    // normal component for this step
    always_comb begin
        case (i_ctl.k)
            2'd0:    coef = i_plane.x;
            2'd1:    coef = i_plane.y;
            default: coef = i_plane.z;
        endcase
    end

    // floored product, running dot product
    assign term    = r_prod >>> FRAC_BITS;
    assign acc_sum = ((r_ctl.k == 2'd0) ? 64'sd0 : r_acc) + term;
    assign acc_abs = acc_sum[63] ? -acc_sum : acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= 64'(coef) * 64'(i_opnd);
        if (r_ctl.go) begin
            r_acc <= acc_sum;
            if (r_ctl.vec == 2'd0 && r_ctl.k == 2'd0) begin
                r_rad <= 64'sd0;
            end
            if (r_ctl.k == 2'd2) begin
                if (r_ctl.vec == 2'd0) begin
                    r_dist <= acc_sum + 64'(i_plane.w);
                end else if (acc_abs > r_rad) begin
                    r_rad <= acc_abs;
                end
            end
        end
    end

    assign o_dist = r_dist;
    assign o_rad  = r_rad;

endmodule

// File: src/fpc_extract.sv
module fpc_extract (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fpc_pkg::t_clip   i_clip,
    output logic             o_busy,
    output fpc_pkg::t_planes o_planes
);
    import fpc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_DSET, S_DIV, S_WR} t_state;

    t_state             r_state;
    logic signed [31:0] raw_init [PLANE_WORDS];
    logic signed [31:0] r_raw    [PLANE_WORDS];
    logic signed [31:0] r_chain  [PLANE_WORDS];
    logic [5:0]         r_cnt;
    logic [2:0]         r_plane;
    logic [1:0]         r_comp;
    logic signed [63:0] r_prod;
    logic [63:0]        r_sq;
    logic [63:0]        r_x;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_len;
    logic [31:0]        r_rem;
    logic [DVD_W-1:0]   r_dvd;
    logic [DVD_W-1:0]   r_q;

    logic signed [31:0] sq_tap;
    logic [63:0]        trial;
    logic               take;
    logic [63:0]        x_n;
    logic [63:0]        res_n;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [32:0]        rem_n;
    logic [31:0]        mag0;
    logic               q_big;
    logic [32:0]        qc;
    logic [32:0]        qneg;
    logic [31:0]        wr_val;

    // raw plane rows, in chain order plane*4+component
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_raw
        for (genvar c = 0; c < 4; c++) begin : g_comp
            assign raw_init[p*4+c] = sat_sum(i_clip[c].w, row_of(i_clip[c], OTHER_ROW[p]),
                                             ADD_ROW[p]);
        end
        assign o_planes[p].x = r_chain[p*4];
        assign o_planes[p].y = r_chain[p*4+1];
        assign o_planes[p].z = r_chain[p*4+2];
        assign o_planes[p].w = r_chain[p*4+3];
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_tap = r_raw[0];
            2'd1:    sq_tap = r_raw[1];
            default: sq_tap = r_raw[2];
        endcase
    end

    // one bit pair of the square root per cycle
    assign trial = r_res + r_bit;
    assign take  = (r_x >= trial);
    assign x_n   = take ? (r_x - trial) : r_x;
    assign res_n = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_len});
    assign rem_n  = ge ? (rem_sh - {1'b0, r_len}) : rem_sh;

    assign mag0 = r_raw[0][31] ? (~r_raw[0] + 32'd1) : r_raw[0];

    // clamp the magnitude to 2^31 and apply the sign of the raw component; +2^31 becomes 2^31-1
    assign q_big  = (|r_q[DVD_W-1:32]) || (r_q[31] && (|r_q[30:0]));
    assign qc     = q_big ? 33'h0_8000_0000 : {1'b0, r_q[31:0]};
    assign qneg   = ~qc + 33'd1;
    assign wr_val = r_raw[0][31] ? qneg[31:0] : (qc[31] ? 32'h7fff_ffff : qc[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_plane <= '0;
            r_comp  <= '0;
            for (int i = 0; i < PLANE_WORDS; i++) begin
                r_chain[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_raw   <= raw_init;
                        r_plane <= '0;
                        r_comp  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= 64'(sq_tap) * 64'(sq_tap);
                    if (r_cnt == 6'd1) begin
                        r_sq <= r_prod;
                    end else if (r_cnt == 6'd2) begin
                        r_sq <= r_sq + r_prod;
                    end
                    if (r_cnt == 6'd3) begin
                        r_x     <= r_sq + r_prod;
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ROOT: begin
                    r_x   <= x_n;
                    r_res <= res_n;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'(ROOT_STEPS - 1)) begin
                        r_len   <= res_n[31:0];
                        r_cnt   <= '0;
                        r_state <= S_DSET;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DSET: begin
                    r_q   <= '0;
                    r_rem <= '0;
                    r_dvd <= DVD_W'(mag0) << FRAC_BITS;
                    r_cnt <= '0;
                    // zero-length normal: plane stays all zeros
                    r_state <= (r_len == 32'd0) ? S_WR : S_DIV;
                end
                S_DIV: begin
                    r_rem <= rem_n[31:0];
                    r_dvd <= r_dvd << 1;
                    r_q   <= {r_q[DVD_W-2:0], ge};
                    if (r_cnt == 6'(DVD_W - 1)) begin
                        r_state <= S_WR;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_WR: begin
                    for (int i = 0; i < PLANE_WORDS - 1; i++) begin
                        r_chain[i] <= r_chain[i+1];
                        r_raw[i]   <= r_raw[i+1];
                    end
                    r_chain[PLANE_WORDS-1] <= wr_val;
                    r_raw[PLANE_WORDS-1]   <= '0;
                    if (r_comp == 2'd3) begin
                        r_comp <= '0;
                        r_cnt  <= '0;
                        if (r_plane == 3'(NUM_PLANES - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_plane <= r_plane + 3'd1;
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_DSET;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/frustum_plane_extract_and_cull.sv
// Frustum culling block, signed Q16.16. A column load (func 0) writes one clip-matrix column
// and rebuilds the six normalized planes in a shared extractor: per plane it sums the squares
// of three row sums, takes a bit-serial square root, then divides each of the 4 components
// bit-serially by that length. Six plane lanes, one multiplier each, run a test in parallel
// and a merge stage combines their reject flags: a sphere test (func 2) issues three
// multiplies and a box test (func 3) twelve, one per cycle per lane, followed by the
// product, accumulate and merge stages; the merge stage waits while a result is not taken.
// Loads give no result; a test gives one o_inside_res transfer.
module frustum_plane_extract_and_cull (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [1:0]         i_slot,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_vec_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_inside_res
);
    import fpc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_XSTART, S_XWAIT, S_ISSUE, S_DRAIN, S_DONE} t_state;

    t_state             r_state;
    t_clip              r_clip;
    t_vec4              r_axis [3];
    t_vec4              r_in;
    t_func              r_func;
    logic [1:0]         r_vec;
    logic [1:0]         r_k;
    logic               r_out_valid;
    logic               r_inside;

    logic               accept;
    logic               x_busy;
    t_planes            planes;
    t_lane_ctl          lane_ctl;
    t_vec4              opnd_vec;
    logic signed [31:0] opnd;
    logic signed [63:0] plane_dist [NUM_PLANES];
    logic signed [63:0] rad  [NUM_PLANES];
    logic [NUM_PLANES-1:0] reject;
    logic               last_issue;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    fpc_extract u_extract (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_XSTART),
        .i_clip   (r_clip),
        .o_busy   (x_busy),
        .o_planes (planes)
    );

    // operand broadcast to all lanes: centre, then the stored axes
    always_comb begin
        opnd_vec = (r_vec == 2'd0) ? r_in : r_axis[r_vec - 2'd1];
        case (r_k)
            2'd0:    opnd = opnd_vec.x;
            2'd1:    opnd = opnd_vec.y;
            default: opnd = opnd_vec.z;
        endcase
    end

    assign lane_ctl.go  = (r_state == S_ISSUE);
    assign lane_ctl.vec = r_vec;
    assign lane_ctl.k   = r_k;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        fpc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (planes[p]),
            .i_ctl   (lane_ctl),
            .i_opnd  (opnd),
            .o_dist  (plane_dist[p]),
            .o_rad   (rad[p])
        );
        // merge: plane rejects when distance <= -radius
        assign reject[p] = (r_func == FN_SPHERE) ? (plane_dist[p] <= -64'(r_in.w))
                                                 : (plane_dist[p] <= -rad[p]);
    end

    assign last_issue = (r_k == 2'd2) && ((r_func == FN_SPHERE) || (r_vec == 2'd3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vec       <= '0;
            r_k         <= '0;
            r_clip      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_axis[i] <= '0;
            end
        end else begin
            // the merge state sets the result itself
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func <= t_func'(i_func);
                        r_in   <= '{x: i_vec_x, y: i_vec_y, z: i_vec_z, w: i_vec_w};
                        r_vec  <= '0;
                        r_k    <= '0;
                        unique case (t_func'(i_func))
                            FN_LOAD_COL: begin
                                r_clip[i_slot] <= '{x: i_vec_x, y: i_vec_y,
                                                    z: i_vec_z, w: i_vec_w};
                                r_state <= S_XSTART;
                            end
                            FN_LOAD_AXIS: begin
                                if (i_slot != 2'd3) begin
                                    r_axis[i_slot] <= '{x: i_vec_x, y: i_vec_y,
                                                        z: i_vec_z, w: 32'sd0};
                                end
                            end
                            FN_SPHERE, FN_BOX: r_state <= S_ISSUE;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_XSTART: r_state <= S_XWAIT;
                S_XWAIT: begin
                    if (!x_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ISSUE: begin
                    if (last_issue) begin
                        r_state <= S_DRAIN;
                    end else if (r_k == 2'd2) begin
                        r_k   <= '0;
                        r_vec <= r_vec + 2'd1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_DRAIN: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_inside    <= ~|reject;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;

    // extractor only runs while the controller waits for it
    a_busy_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_busy |-> (r_state == S_XWAIT))
        else $error("extractor busy outside wait state");

    // a result only appears out of the merge state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised without a finished test");

    // sphere test only ever issues the centre vector
    a_sphere_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE && r_func == FN_SPHERE) |-> (r_vec == 2'd0))
        else $error("sphere test issued an axis vector");

endmodule

// File: test/frustum_plane_extract_and_cull_tb.sv
module frustum_plane_extract_and_cull_tb;
    import fpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1600;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [1:0]         i_slot;
    logic signed [31:0] i_vec_x;
    logic signed [31:0] i_vec_y;
    logic signed [31:0] i_vec_z;
    logic signed [31:0] i_vec_w;
    logic               o_valid;
    logic               i_ready;
    logic               o_inside_res;

    frustum_plane_extract_and_cull dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_slot(i_slot), .i_vec_x(i_vec_x), .i_vec_y(i_vec_y),
        .i_vec_z(i_vec_z), .i_vec_w(i_vec_w), .o_valid(o_valid), .i_ready(i_ready),
        .o_inside_res(o_inside_res)
    );

    // predictor state
    logic signed [31:0] clip_m [16];
    logic signed [31:0] plane_m [24];
    logic signed [31:0] axis_m [9];
    logic               inside_q [$];

    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     quiet_cycles;
    bit     failed;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fshift(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // rebuild the six normalized planes from the clip matrix
    task automatic rebuild_planes();
        int oth [6];
        bit addr [6];
        longint raw [4];
        longint unsigned sq, len, q, mag;
        longint a, b, o;
        oth = '{0, 0, 1, 1, 2, 2};
        addr = '{0, 1, 1, 0, 0, 1};
        for (int p = 0; p < 6; p++) begin
            sq = 0;
            for (int c = 0; c < 4; c++) begin
                a = clip_m[c*4+3];
                b = clip_m[c*4+oth[p]];
                raw[c] = sat32(addr[p] ? a + b : a - b);
            end
            for (int c = 0; c < 3; c++) sq += longint'(raw[c] * raw[c]);
            len = root64(sq);
            for (int c = 0; c < 4; c++) begin
                o = 0;
                if (len != 0) begin
                    mag = raw[c] < 0 ? -raw[c] : raw[c];
                    q = (mag << FRAC_BITS) / len;
                    if (q > 64'd2147483648) q = 64'd2147483648;
                    o = raw[c] < 0 ? -longint'(q) : longint'(q);
                end
                plane_m[p*4+c] = sat32(o);
            end
        end
    endtask

    function automatic longint plane_dot(input int p, input longint x, input longint y,
                                         input longint z);
        return fshift(longint'(plane_m[p*4]) * x) + fshift(longint'(plane_m[p*4+1]) * y)
             + fshift(longint'(plane_m[p*4+2]) * z);
    endfunction

    // apply one item to the predictor; a test queues its inside flag
    task automatic predict_cull(input logic [1:0] fn, input logic [1:0] sl,
                                input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z, input logic signed [31:0] w);
        bit in_flag;
        longint dist_v, r, v;
        in_flag = 1'b1;
        case (t_func'(fn))
            FN_LOAD_COL: begin
                clip_m[sl*4] = x; clip_m[sl*4+1] = y;
                clip_m[sl*4+2] = z; clip_m[sl*4+3] = w;
                rebuild_planes();
            end
            FN_LOAD_AXIS: begin
                if (sl < 3) begin
                    axis_m[sl*3] = x; axis_m[sl*3+1] = y; axis_m[sl*3+2] = z;
                end
            end
            default: begin
                for (int p = 0; p < 6 && in_flag; p++) begin
                    dist_v = plane_dot(p, x, y, z) + longint'(plane_m[p*4+3]);
                    if (t_func'(fn) == FN_SPHERE) begin
                        r = w;
                    end else begin
                        r = 0;
                        for (int a = 0; a < 3; a++) begin
                            v = plane_dot(p, axis_m[a*3], axis_m[a*3+1], axis_m[a*3+2]);
                            if (v < 0) v = -v;
                            if (v > r) r = v;
                        end
                    end
                    if (dist_v <= -r) in_flag = 1'b0;
                end
                inside_q.push_back(in_flag);
            end
        endcase
    endtask

    // send one item, idling first at random
    task automatic send_item(input logic [1:0] fn, input logic [1:0] sl,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn; i_slot <= sl;
        i_vec_x <= x; i_vec_y <= y; i_vec_z <= z; i_vec_w <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_cull(fn, sl, x, y, z, w);
    endtask

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (inside_q.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %0b", o_inside_res);
            end else begin
                logic exp_in;
                exp_in = inside_q.pop_front();
                if (o_inside_res !== exp_in) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("inside_res mismatch: expected %0b actual %0b",
                                 exp_in, o_inside_res);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("frustum_plane_extract_and_cull_tb: FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'sh8000_0000 + $urandom_range(3);
            2:       return 32'sh7fff_ffff - $urandom_range(3);
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // load all four columns with random words, some of them near the 32-bit extremes
    task automatic load_random_matrix();
        for (int c = 0; c < 4; c++)
            send_item(FN_LOAD_COL, c[1:0], rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic test_directed();
        // all-zero planes never reject positive radius; zero or negative radius and a box are rejected
        send_item(FN_SPHERE, 2'd0, 0, 0, 0, 32'sh0001_0000);
        send_item(FN_SPHERE, 2'd0, 0, 0, 0, 0);
        send_item(FN_SPHERE, 2'd0, 0, 0, 0, -32'sh0001_0000);
        send_item(FN_BOX, 2'd0, 0, 0, 0, 0);
        // identity matrix: unit cube frustum
        send_item(FN_LOAD_COL, 2'd0, 32'sh0001_0000, 0, 0, 0);
        send_item(FN_LOAD_COL, 2'd1, 0, 32'sh0001_0000, 0, 0);
        send_item(FN_LOAD_COL, 2'd2, 0, 0, 32'sh0001_0000, 0);
        send_item(FN_LOAD_COL, 2'd3, 0, 0, 0, 32'sh0001_0000);
        send_item(FN_SPHERE, 2'd0, 0, 0, 0, 32'sh0000_8000);
        send_item(FN_SPHERE, 2'd0, 32'sh0003_0000, 0, 0, 32'sh0000_8000);
        send_item(FN_SPHERE, 2'd0, 32'sh0001_8000, 0, 0, 32'sh0000_8000);
        send_item(FN_SPHERE, 2'd0, 0, 0, 0, 32'sh8000_0000);
        // box axes, slot three ignored
        send_item(FN_LOAD_AXIS, 2'd0, 32'sh0001_0000, 0, 0, 0);
        send_item(FN_LOAD_AXIS, 2'd1, 0, 32'sh0000_8000, 0, 0);
        send_item(FN_LOAD_AXIS, 2'd2, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(FN_LOAD_AXIS, 2'd3, 32'sh8000_0000, 32'sh7fff_ffff, -1, -1);
        send_item(FN_BOX, 2'd1, 32'sh0002_0000, 0, 0, 32'sh7fff_ffff);
        send_item(FN_BOX, 2'd2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        // saturating row sums
        send_item(FN_LOAD_COL, 2'd0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff);
        send_item(FN_LOAD_COL, 2'd3, 32'sh7fff_ffff, 32'sh8000_0000, -1, 32'sh8000_0000);
        send_item(FN_SPHERE, 2'd3, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -1);
        send_item(FN_BOX, 2'd3, -1, -1, -1, -1);
    endtask

    // mostly tests with random content, matrix reloads now and then
    task automatic test_random(input int n);
        logic [1:0] fn;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(199) == 0) begin
                load_random_matrix();
            end else begin
                case ($urandom_range(19))
                    0:       fn = FN_LOAD_COL;
                    1, 2:    fn = FN_LOAD_AXIS;
                    3, 4, 5, 6, 7, 8, 9, 10, 11: fn = FN_SPHERE;
                    default: fn = FN_BOX;
                endcase
                send_item(fn, 2'($urandom), rand_word(), rand_word(), rand_word(),
                          rand_word());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_func = '0; i_slot = '0;
        i_vec_x = '0; i_vec_y = '0; i_vec_z = '0; i_vec_w = '0;
        mismatches = 0; failed = 1'b0; quiet_cycles = 0;
        send_idle_pct = 17; recv_idle_pct = 70;
        for (int i = 0; i < 16; i++) clip_m[i] = '0;
        for (int i = 0; i < 24; i++) plane_m[i] = '0;
        for (int i = 0; i < 9; i++) axis_m[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        send_idle_pct = 70; recv_idle_pct = 17;
        test_random(500);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(500);
        i_valid <= 1'b0;
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && inside_q.size() == 0) begin
            $display("frustum_plane_extract_and_cull_tb: PASS");
        end else begin
            $display("frustum_plane_extract_and_cull_tb: FAIL");
        end
        $finish;
    end

endmodule
